// ===== rtl/acl_pkg.sv =====
`default_nettype none

package acl_pkg;

    // rule table geometry
    localparam int MAX_RULES = 16;
    localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W     = $clog2(MAX_RULES + 1);

    // command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;

    // status codes
    localparam logic [1:0] ST_ALLOW  = 2'd0;
    localparam logic [1:0] ST_DENY   = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [31:0] address;
        logic [3:0]  wildcard_mask;
        logic        allow;
    } acl_rule_t;

endpackage

`default_nettype wire

// ===== rtl/ipv4_wildcard_acl_first_match.sv =====
`default_nettype none

// Channel   Handshake            Fields
// --------  -------------------  ------------------------------------------
// command   start / busy         cmd, address, wildcard_mask, rule_allow
// result    done (1-cycle pulse) status, matched, match_index
//
// A command transaction is taken on a rising edge with start high and busy low.
// Add, flush and the unused code answer in the cycle after acceptance.
// Check reads one rule per cycle from the rule RAM, starting at the first stored
// rule, and answers with the first hit, or with deny after the last stored rule
// misses; an empty list is denied at once.
// The registered RAM read port sets that pace.
// rst_n clears the rule count and the control state; RAM contents are not reset.
// The receiver cannot stall: done is a single-cycle strobe.
module ipv4_wildcard_acl_first_match
    import acl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] address,
    input  wire logic [3:0]  wildcard_mask,
    input  wire logic        rule_allow,
    output logic             done,
    output logic [1:0]       status,
    output logic             matched,
    output logic [3:0]       match_index
);

    localparam logic STATE_IDLE = 1'b0;
    localparam logic STATE_SCAN = 1'b1;

    // rule RAM: one write port (add), one registered read port (scan)
    acl_rule_t rule_mem [MAX_RULES];
    acl_rule_t rd_data_reg;
    logic [IDX_W-1:0] rd_addr;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      key_reg;          // address under check

    logic             done_reg, done_next;
    logic [1:0]       status_reg, status_next;
    logic             matched_reg, matched_next;
    logic [3:0]       index_reg, index_next;

    logic             accept;
    logic             table_full;
    logic             last_rule;
    logic             hit;
    logic [31:0]      idx_wide;

    assign accept     = start && (state_reg == STATE_IDLE);
    assign table_full = (count_reg == CNT_W'(MAX_RULES));
    // current rule is the last valid one
    assign last_rule  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign idx_wide   = 32'(idx_reg);

    acl_match u_match (
        .rule    (rd_data_reg),
        .address (key_reg),
        .hit     (hit)
    );

    // read-ahead: while rule idx is compared, rule idx+1 is fetched
    always_comb
    begin
        if (state_reg == STATE_IDLE)
        begin
            rd_addr = '0;
        end
        else if (last_rule)
        begin
            rd_addr = idx_reg;
        end
        else
        begin
            rd_addr = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        // busy keeps adds out of a running scan, so no read/write overlap
        if (accept && (cmd == CMD_ADD) && !table_full)
        begin
            rule_mem[count_reg[IDX_W-1:0]] <= '{address, wildcard_mask, rule_allow};
        end
        rd_data_reg <= rule_mem[rd_addr];
        if (accept)
        begin
            key_reg <= address;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        matched_next = matched_reg;
        index_next   = index_reg;

        unique case (state_reg)
            STATE_IDLE:
            begin
                if (accept)
                begin
                    status_next  = ST_ALLOW;
                    matched_next = 1'b0;
                    index_next   = '0;
                    unique case (cmd)
                        CMD_ADD:
                        begin
                            done_next = 1'b1;
                            if (table_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_FLUSH:
                        begin
                            done_next  = 1'b1;
                            count_next = '0;
                        end
                        CMD_CHECK:
                        begin
                            if (count_reg == '0)
                            begin
                                // empty list denies at once
                                done_next   = 1'b1;
                                status_next = ST_DENY;
                            end
                            else
                            begin
                                state_next = STATE_SCAN;
                                idx_next   = '0;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            STATE_SCAN:
            begin
                priority if (hit)
                begin
                    done_next    = 1'b1;
                    matched_next = 1'b1;
                    index_next   = idx_wide[3:0];
                    status_next  = rd_data_reg.allow ? ST_ALLOW : ST_DENY;
                    state_next   = STATE_IDLE;
                end
                else if (last_rule)
                begin
                    done_next   = 1'b1;
                    status_next = ST_DENY;
                    state_next  = STATE_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= STATE_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            done_reg    <= 1'b0;
            status_reg  <= ST_ALLOW;
            matched_reg <= 1'b0;
            index_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            matched_reg <= matched_next;
            index_reg   <= index_next;
        end
    end

    assign busy        = (state_reg == STATE_SCAN);
    assign done        = done_reg;
    assign status      = status_reg;
    assign matched     = matched_reg;
    assign match_index = index_reg;

endmodule

`default_nettype wire

// ===== rtl/acl_match.sv =====
`default_nettype none

// Octet compare of one stored rule against the address under check.
module acl_match
    import acl_pkg::*;
(
    input  wire acl_rule_t   rule,
    input  wire logic [31:0] address,
    output logic             hit
);

    logic [3:0] octet_ok;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            // mask bit 3 covers the first octet (bits 31..24)
            octet_ok[3 - k] = rule.wildcard_mask[3 - k]
                || (rule.address[31 - 8 * k -: 8] == address[31 - 8 * k -: 8]);
        end
    end

    assign hit = &octet_ok;

endmodule

`default_nettype wire

// ===== rtl/acl_checker.sv =====
`default_nettype none

module acl_checker
    import acl_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  cmd,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic        matched,
    input wire logic [3:0]  match_index
);

    // non-check commands answer in the next cycle
    a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd != CMD_CHECK)) |=> done)
        else $error("add/flush transaction not answered next cycle");

    // a result always frees the command side
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_index_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !matched) |-> (match_index == 4'd0))
        else $error("match_index set without a match");

    a_full_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> !matched)
        else $error("table full reported with a match");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == ST_ALLOW) || (status == ST_DENY) || (status == ST_FULL)))
        else $error("undefined status code");

endmodule

bind ipv4_wildcard_acl_first_match acl_checker u_acl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .status      (status),
    .matched     (matched),
    .match_index (match_index)
);

`default_nettype wire
